@@ rtl/core/periodic_sensor_averager_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the periodic sensor averager
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_SENSOR_AVERAGER_DEFINES_SVH
`define PERIODIC_SENSOR_AVERAGER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every edge
`define PSA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define PSA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PSA_ASSERT_ALWAYS(label, cond)
`define PSA_ASSERT_IMPL(label, ante, cons)
`define PSA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ rtl/core/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Types, constants and microcode table of the periodic sensor averager.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psa_pkg;

    // sample counter width
    localparam int COUNT_BITS = 16;

    // register reset values and scaling
    localparam logic [31:0] PERIOD_RESET = 32'd60000;
    localparam logic [3:0]  RATIO_RESET  = 4'd3;
    localparam int          SCALE_TEN    = 10;

    // fault mask bit positions
    localparam int FAULT_TH_BIT   = 0;
    localparam int FAULT_RAIN_BIT = 1;
    localparam int FAULT_CO2_BIT  = 3;
    localparam int FAULT_CO_BIT   = 4;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATIO  = 1'b1;

    // stream widths
    localparam int IN_DATA_BITS  = 64;
    localparam int OUT_DATA_BITS = 96;

    // rain compare width: max(rain*10, count*ratio)
    localparam int RAIN_PROD_BITS = (COUNT_BITS + 4 > 20) ? COUNT_BITS + 4 : 20;

    // divider: 32-bit dividend, four quotient bits per cycle
    localparam int DIV_WIDTH     = 32;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_ITERS     = DIV_WIDTH / DIV_STEP_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_ITERS);

    // accumulator select
    typedef logic [1:0] psa_sel_t;
    localparam psa_sel_t SEL_TEMP = 2'd0;
    localparam psa_sel_t SEL_HUMI = 2'd1;
    localparam psa_sel_t SEL_CO2  = 2'd2;
    localparam psa_sel_t SEL_CO   = 2'd3;

    // datapath operations
    typedef enum logic [2:0] {
        OP_WAIT_IN,
        OP_UPDATE,
        OP_NOP,
        OP_DIV_START,
        OP_DIV_RUN,
        OP_EMIT,
        OP_CLEAR
    } psa_op_t;

    // jump conditions
    typedef enum logic [2:0] {
        JC_NEXT,
        JC_ALWAYS,
        JC_NO_ACCEPT,
        JC_DIV_BUSY,
        JC_OUT_BUSY,
        JC_NOT_DUE,
        JC_EMPTY
    } psa_jc_t;

    localparam int PC_BITS = 4;
    typedef logic [PC_BITS-1:0] psa_pc_t;

    // program steps
    localparam psa_pc_t STEP_WAIT    = 4'd0;
    localparam psa_pc_t STEP_UPDATE  = 4'd1;
    localparam psa_pc_t STEP_DUE     = 4'd2;
    localparam psa_pc_t STEP_EMPTY   = 4'd3;
    localparam psa_pc_t STEP_ST_TEMP = 4'd4;
    localparam psa_pc_t STEP_RN_TEMP = 4'd5;
    localparam psa_pc_t STEP_ST_HUMI = 4'd6;
    localparam psa_pc_t STEP_RN_HUMI = 4'd7;
    localparam psa_pc_t STEP_ST_CO2  = 4'd8;
    localparam psa_pc_t STEP_RN_CO2  = 4'd9;
    localparam psa_pc_t STEP_ST_CO   = 4'd10;
    localparam psa_pc_t STEP_RN_CO   = 4'd11;
    localparam psa_pc_t STEP_EMIT    = 4'd12;
    localparam psa_pc_t STEP_CLEAR   = 4'd13;

    // one control word
    typedef struct packed {
        psa_op_t  op;
        psa_sel_t sel;
        psa_jc_t  jc;
        psa_pc_t  target;
    } psa_uword_t;

    // sequencer status inputs
    typedef struct packed {
        logic in_accept;
        logic div_busy;
        logic out_busy;
        logic not_due;
        logic empty;
    } psa_status_t;

    // microcode ROM
    function automatic psa_uword_t psa_ucode(input psa_pc_t pc);
        psa_uword_t w;
        w = '{op: OP_WAIT_IN, sel: SEL_TEMP, jc: JC_NO_ACCEPT, target: STEP_WAIT};
        unique case (pc)
            STEP_WAIT:    w = '{OP_WAIT_IN,   SEL_TEMP, JC_NO_ACCEPT, STEP_WAIT};
            STEP_UPDATE:  w = '{OP_UPDATE,    SEL_TEMP, JC_NEXT,      STEP_WAIT};
            STEP_DUE:     w = '{OP_NOP,       SEL_TEMP, JC_NOT_DUE,   STEP_WAIT};
            STEP_EMPTY:   w = '{OP_NOP,       SEL_TEMP, JC_EMPTY,     STEP_CLEAR};
            STEP_ST_TEMP: w = '{OP_DIV_START, SEL_TEMP, JC_NEXT,      STEP_WAIT};
            STEP_RN_TEMP: w = '{OP_DIV_RUN,   SEL_TEMP, JC_DIV_BUSY,  STEP_RN_TEMP};
            STEP_ST_HUMI: w = '{OP_DIV_START, SEL_HUMI, JC_NEXT,      STEP_WAIT};
            STEP_RN_HUMI: w = '{OP_DIV_RUN,   SEL_HUMI, JC_DIV_BUSY,  STEP_RN_HUMI};
            STEP_ST_CO2:  w = '{OP_DIV_START, SEL_CO2,  JC_NEXT,      STEP_WAIT};
            STEP_RN_CO2:  w = '{OP_DIV_RUN,   SEL_CO2,  JC_DIV_BUSY,  STEP_RN_CO2};
            STEP_ST_CO:   w = '{OP_DIV_START, SEL_CO,   JC_NEXT,      STEP_WAIT};
            STEP_RN_CO:   w = '{OP_DIV_RUN,   SEL_CO,   JC_DIV_BUSY,  STEP_RN_CO};
            STEP_EMIT:    w = '{OP_EMIT,      SEL_TEMP, JC_OUT_BUSY,  STEP_EMIT};
            STEP_CLEAR:   w = '{OP_CLEAR,     SEL_TEMP, JC_ALWAYS,    STEP_WAIT};
            default:      w = '{OP_WAIT_IN,   SEL_TEMP, JC_ALWAYS,    STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/core/psa_div.sv @@
// ----------------------------------------------------------------------------
// psa_div
// Restoring divider, 32-bit dividend by sample count, four bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psa_div
    import psa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIV_WIDTH-1:0]  dividend,
    input  logic [COUNT_BITS-1:0] divisor,
    output logic                  busy,
    output logic [DIV_WIDTH-1:0]  quotient
);

    logic                    busy_reg;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_WIDTH-1:0]    quo_reg;
    logic [DIV_WIDTH-1:0]    quo_next;
    logic [COUNT_BITS-1:0]   rem_reg;
    logic [COUNT_BITS-1:0]   rem_next;
    logic [COUNT_BITS-1:0]   dsr_reg;

    // four shift/compare/subtract steps
    always_comb
    begin
        logic [COUNT_BITS:0]   trial;
        logic [COUNT_BITS-1:0] r;
        logic [DIV_WIDTH-1:0]  q;
        r = rem_reg;
        q = quo_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP_BITS; i++)
        begin
            trial = {r, q[DIV_WIDTH-1]};
            q = {q[DIV_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
                q[0] = 1'b1;
            end
            r = trial[COUNT_BITS-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_BITS'(DIV_ITERS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/core/psa_seq.sv @@
// ----------------------------------------------------------------------------
// psa_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psa_seq
    import psa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  psa_status_t status,
    output psa_uword_t  uword
);

    psa_pc_t    pc_reg;
    psa_pc_t    pc_next;
    psa_uword_t word;
    logic       taken;

    // control word fetch
    assign word  = psa_ucode(pc_reg);
    assign uword = word;

    // jump condition
    always_comb
    begin
        unique case (word.jc)
            JC_NEXT:      taken = 1'b0;
            JC_ALWAYS:    taken = 1'b1;
            JC_NO_ACCEPT: taken = !status.in_accept;
            JC_DIV_BUSY:  taken = status.div_busy;
            JC_OUT_BUSY:  taken = status.out_busy;
            JC_NOT_DUE:   taken = status.not_due;
            JC_EMPTY:     taken = status.empty;
            default:      taken = 1'b1;
        endcase
        pc_next = taken ? word.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT;
        else
            pc_reg <= pc_next;
    end

endmodule

@@ rtl/core/periodic_sensor_averager.sv @@
// ----------------------------------------------------------------------------
// periodic_sensor_averager
// Accumulates sensor samples over a tick period and emits truncated means.
// ----------------------------------------------------------------------------
// Input stream s_axis: one beat is a sample (tuser 0) or one time tick
// (tuser 1). Output stream m_axis: one beat per period that saw samples,
// holding the four means, the count, the rain flag and the last fault bits.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 period in ticks,
// index 1 rain ratio in tenths; write only while the block is idle.
// Sequencing: a small microcoded sequencer runs every beat, and the next beat
// is accepted only back in its wait step. A beat that does not close the
// period passes the update and due-check steps; a beat that closes a period
// without samples also passes the empty check and the clear step.
// A beat that closes a period with samples runs four divisions in turn on
// the one shared divider (four quotient bits a cycle), plus the update,
// checks, output load and clear steps.
// The result sits in an output register; the next input beat is accepted
// while it waits. If the receiver still holds the previous result when the
// next one is ready, the sequencer waits in its output step.
// Reset clears all sums, counters and fault bits and loads the register
// defaults (60000 ticks, ratio 3).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "periodic_sensor_averager_defines.svh"

module periodic_sensor_averager
    import psa_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]               cfg_data,
    // input stream
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // temperature[7:0], humidity[15:8], rain_raw[16], co2_level[32:17],
    // co_level[48:33], fault_bits[56:49], zero fill
    input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
    // command[0]
    input  logic                      s_axis_tuser,
    // output stream
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // temp_mean_x10[15:0], humi_mean_x10[31:16], co2_mean[47:32],
    // co_mean[63:48], samples_in_period[79:64], rain_alert[80],
    // last_faults[88:81], zero fill
    output logic [OUT_DATA_BITS-1:0]  m_axis_tdata
);

    // configuration registers
    logic [31:0] period_reg;
    logic [3:0]  ratio_reg;

    // captured input beat
    logic        in_cmd_reg;
    logic [7:0]  in_temp_reg;
    logic [7:0]  in_humi_reg;
    logic        in_rain_reg;
    logic [15:0] in_co2_reg;
    logic [15:0] in_co_reg;
    logic [7:0]  in_fault_reg;

    // accumulators
    logic [31:0]           temp_total_reg;
    logic [31:0]           humi_total_reg;
    logic [31:0]           co2_total_reg;
    logic [31:0]           co_total_reg;
    logic [15:0]           rain_total_reg;
    logic [COUNT_BITS-1:0] sample_total_reg;
    logic [7:0]            recent_faults_reg;
    logic [31:0]           elapsed_reg;

    // quotients, one per accumulator
    logic [15:0] mean_reg [4];

    // output register
    logic                     out_valid_reg;
    logic [OUT_DATA_BITS-1:0] out_data_reg;
    logic [OUT_DATA_BITS-1:0] out_data_next;

    psa_uword_t  uword;
    psa_status_t status;

    logic                  in_accept;
    logic                  out_busy;
    logic                  out_load;
    logic                  div_start;
    logic                  div_busy;
    logic [DIV_WIDTH-1:0]  div_dividend;
    logic [DIV_WIDTH-1:0]  div_quotient;
    logic [11:0]           temp_x10;
    logic [11:0]           humi_x10;
    logic [RAIN_PROD_BITS-1:0] rain_lhs;
    logic [RAIN_PROD_BITS-1:0] rain_rhs;
    logic                  rain_alert;
    logic [31:0]           count_wide;

    // handshake decode
    assign s_axis_tready = (uword.op == OP_WAIT_IN);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign out_load      = (uword.op == OP_EMIT) && !out_busy;
    assign div_start     = (uword.op == OP_DIV_START);

    // sequencer
    always_comb
    begin
        status.in_accept = in_accept;
        status.div_busy  = div_busy;
        status.out_busy  = out_busy;
        status.not_due   = elapsed_reg < period_reg;
        status.empty     = (sample_total_reg == '0);
    end

    psa_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .uword  (uword)
    );

    // divider operand select
    always_comb
    begin
        unique case (uword.sel)
            SEL_TEMP: div_dividend = temp_total_reg;
            SEL_HUMI: div_dividend = humi_total_reg;
            SEL_CO2:  div_dividend = co2_total_reg;
            SEL_CO:   div_dividend = co_total_reg;
            default:  div_dividend = temp_total_reg;
        endcase
    end

    psa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (sample_total_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            ratio_reg  <= RATIO_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_PERIOD)
                period_reg <= cfg_data;
            else if (cfg_index == REG_RATIO)
                ratio_reg <= cfg_data[3:0];
        end
    end

    // capture input beat
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_temp_reg  <= s_axis_tdata[7:0];
            in_humi_reg  <= s_axis_tdata[15:8];
            in_rain_reg  <= s_axis_tdata[16];
            in_co2_reg   <= s_axis_tdata[32:17];
            in_co_reg    <= s_axis_tdata[48:33];
            in_fault_reg <= s_axis_tdata[56:49];
        end
    end

    assign temp_x10 = 12'(in_temp_reg) * 12'(SCALE_TEN);
    assign humi_x10 = 12'(in_humi_reg) * 12'(SCALE_TEN);

    // accumulate and clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_total_reg    <= '0;
            humi_total_reg    <= '0;
            co2_total_reg     <= '0;
            co_total_reg      <= '0;
            rain_total_reg    <= '0;
            sample_total_reg  <= '0;
            recent_faults_reg <= '0;
            elapsed_reg       <= '0;
        end
        else if (uword.op == OP_CLEAR)
        begin
            temp_total_reg   <= '0;
            humi_total_reg   <= '0;
            co2_total_reg    <= '0;
            co_total_reg     <= '0;
            rain_total_reg   <= '0;
            sample_total_reg <= '0;
            elapsed_reg      <= '0;
        end
        else if (uword.op == OP_UPDATE)
        begin
            if (!in_cmd_reg)
            begin
                if (!in_fault_reg[FAULT_TH_BIT])
                begin
                    temp_total_reg <= temp_total_reg + 32'(temp_x10);
                    humi_total_reg <= humi_total_reg + 32'(humi_x10);
                end
                // raw level 0 means rain; count saturates
                if (!in_fault_reg[FAULT_RAIN_BIT] && !in_rain_reg
                    && rain_total_reg != 16'hFFFF)
                    rain_total_reg <= rain_total_reg + 16'd1;
                if (!in_fault_reg[FAULT_CO2_BIT])
                    co2_total_reg <= co2_total_reg + 32'(in_co2_reg);
                if (!in_fault_reg[FAULT_CO_BIT])
                    co_total_reg <= co_total_reg + 32'(in_co_reg);
                if (sample_total_reg != '1)
                    sample_total_reg <= sample_total_reg + 1'b1;
                recent_faults_reg <= in_fault_reg;
            end
            else if (elapsed_reg != 32'hFFFF_FFFF)
            begin
                elapsed_reg <= elapsed_reg + 32'd1;
            end
        end
    end

    // store finished quotient
    always_ff @(posedge clk)
    begin
        if (uword.op == OP_DIV_RUN && !div_busy)
            mean_reg[uword.sel] <= div_quotient[15:0];
    end

    // rain flag and result word
    assign rain_lhs   = RAIN_PROD_BITS'(rain_total_reg) * RAIN_PROD_BITS'(SCALE_TEN);
    assign rain_rhs   = RAIN_PROD_BITS'(sample_total_reg) * RAIN_PROD_BITS'(ratio_reg);
    assign rain_alert = rain_lhs >= rain_rhs;
    assign count_wide = 32'(sample_total_reg);

    always_comb
    begin
        out_data_next = {7'b0, recent_faults_reg, rain_alert, count_wide[15:0],
                         mean_reg[SEL_CO], mean_reg[SEL_CO2],
                         mean_reg[SEL_HUMI], mean_reg[SEL_TEMP]};
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // checks
    `PSA_ASSERT_ALWAYS(a_no_accept_in_div, !(s_axis_tready && div_busy))
    `PSA_ASSERT_IMPL(a_load_not_over_held, out_load, !out_busy && sample_total_reg != '0)
    `PSA_ASSERT_NEXT(a_clear_resets_period, uword.op == OP_CLEAR,
                     elapsed_reg == '0 && sample_total_reg == '0)

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Testbench for periodic_sensor_averager
// Drives sample and tick beats, predicts the per-period means, rain flag and
// fault bits, and checks every output beat against the predicted queue.
// Directed beats first, then random phases with different period, ratio and
// handshake idling, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import psa_pkg::*;

    // beat kinds on s_axis_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // cycles to let the sequencer settle once nothing is expected
    localparam int QUIET_CYCLES = 64;
    // length of the long receiver hold-off
    localparam int HOLD_CYCLES  = 500;

    // command above the input tdata layout, lowest field last
    typedef struct packed {
        logic        command;
        logic [6:0]  zero_fill;
        logic [7:0]  fault_bits;
        logic [15:0] co_level;
        logic [15:0] co2_level;
        logic        rain_raw;
        logic [7:0]  humidity;
        logic [7:0]  temperature;
    } sensor_item_t;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]  zero_fill;
        logic [7:0]  last_faults;
        logic        rain_alert;
        logic [15:0] samples_in_period;
        logic [15:0] co_mean;
        logic [15:0] co2_mean;
        logic [15:0] humi_mean_x10;
        logic [15:0] temp_mean_x10;
    } period_means_t;

    // Predicts the period means and checks output beats in order
    class mean_scoreboard;
        logic [31:0]           period_ticks;
        logic [3:0]            ratio_tenths;
        logic [31:0]           temp_acc;
        logic [31:0]           humi_acc;
        logic [31:0]           co2_sum;
        logic [31:0]           co_sum;
        logic [15:0]           rain_hits;
        logic [COUNT_BITS-1:0] n_samples;
        logic [7:0]            faults_seen;
        logic [31:0]           ticks_seen;
        period_means_t         expected_means[$];
        int                    errors;

        function void clear_period();
            temp_acc     = '0;
            humi_acc     = '0;
            co2_sum      = '0;
            co_sum       = '0;
            rain_hits    = '0;
            n_samples    = '0;
            ticks_seen   = '0;
        endfunction

        function void clear_all();
            period_ticks = PERIOD_RESET;
            ratio_tenths = RATIO_RESET;
            faults_seen  = '0;
            errors       = 0;
            clear_period();
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] value);
            if (idx == REG_PERIOD)
                period_ticks = value;
            else if (idx == REG_RATIO)
                ratio_tenths = value[3:0];
        endfunction

        // accumulate one accepted beat, queue the means when the period closes
        function void note_reading(sensor_item_t r);
            period_means_t m;
            logic [63:0]   cnt;
            logic [63:0]   q;
            if (r.command == CMD_SAMPLE)
            begin
                if (!r.fault_bits[FAULT_TH_BIT])
                begin
                    temp_acc = temp_acc + {24'd0, r.temperature} * 32'd10;
                    humi_acc = humi_acc + {24'd0, r.humidity} * 32'd10;
                end
                if (!r.fault_bits[FAULT_RAIN_BIT] && !r.rain_raw && rain_hits != 16'hFFFF)
                    rain_hits = rain_hits + 16'd1;
                if (!r.fault_bits[FAULT_CO2_BIT])
                    co2_sum = co2_sum + {16'd0, r.co2_level};
                if (!r.fault_bits[FAULT_CO_BIT])
                    co_sum = co_sum + {16'd0, r.co_level};
                if (n_samples != '1)
                    n_samples = n_samples + 1'b1;
                faults_seen = r.fault_bits;
            end
            else if (ticks_seen != 32'hFFFF_FFFF)
            begin
                ticks_seen = ticks_seen + 32'd1;
            end

            // period end, checked after samples too
            if (ticks_seen >= period_ticks)
            begin
                if (n_samples != '0)
                begin
                    m   = '0;
                    cnt = '0;
                    cnt[COUNT_BITS-1:0] = n_samples;
                    q = {32'd0, temp_acc} / cnt;
                    m.temp_mean_x10 = q[15:0];
                    q = {32'd0, humi_acc} / cnt;
                    m.humi_mean_x10 = q[15:0];
                    q = {32'd0, co2_sum} / cnt;
                    m.co2_mean = q[15:0];
                    q = {32'd0, co_sum} / cnt;
                    m.co_mean = q[15:0];
                    m.samples_in_period = cnt[15:0];
                    m.rain_alert = ({48'd0, rain_hits} * 64'd10) >=
                                   (cnt * {60'd0, ratio_tenths});
                    m.last_faults = faults_seen;
                    expected_means.push_back(m);
                end
                clear_period();
            end
        endfunction

        function void compare_field(string label, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, label, want, got);
                errors++;
            end
        endfunction

        function void check_means(period_means_t got);
            period_means_t want;
            if (expected_means.size() == 0)
            begin
                $display("%0t: unexpected output beat: expected none, actual %0h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_means.pop_front();
                compare_field("temp_mean_x10", 32'(want.temp_mean_x10),
                              32'(got.temp_mean_x10));
                compare_field("humi_mean_x10", 32'(want.humi_mean_x10),
                              32'(got.humi_mean_x10));
                compare_field("co2_mean", 32'(want.co2_mean), 32'(got.co2_mean));
                compare_field("co_mean", 32'(want.co_mean), 32'(got.co_mean));
                compare_field("samples_in_period", 32'(want.samples_in_period),
                              32'(got.samples_in_period));
                compare_field("rain_alert", 32'(want.rain_alert), 32'(got.rain_alert));
                compare_field("last_faults", 32'(want.last_faults), 32'(got.last_faults));
                compare_field("zero_fill", 32'(want.zero_fill), 32'(got.zero_fill));
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [31:0]               cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    // temperature, humidity, rain_raw, co2_level, co_level, fault_bits, zero fill
    logic [IN_DATA_BITS-1:0]   s_axis_tdata;
    // command
    logic                      s_axis_tuser;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    // temp_mean_x10, humi_mean_x10, co2_mean, co_mean, samples_in_period,
    // rain_alert, last_faults, zero fill
    logic [OUT_DATA_BITS-1:0]  m_axis_tdata;

    mean_scoreboard sb;
    int             tx_idle_pct;
    int             rx_stall_pct;
    logic           rx_hold;

    periodic_sensor_averager uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always #5 clk = ~clk;

    // receiver: random stalls, forced low during a hold-off
    always @(posedge clk)
    begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // input monitor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_reading({s_axis_tuser, s_axis_tdata});
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_means(m_axis_tdata);
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // offer one beat, keep tvalid high after acceptance
    task automatic send_item(input sensor_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.command;
        s_axis_tdata  <= it[IN_DATA_BITS-1:0];
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic sensor_item_t random_item(input int tick_pct);
        sensor_item_t it;
        it             = '0;
        it.command     = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_SAMPLE;
        it.temperature = 8'($urandom_range(255));
        it.humidity    = 8'($urandom_range(255));
        it.rain_raw    = 1'($urandom_range(1));
        it.co2_level   = 16'($urandom_range(65535));
        it.co_level    = 16'($urandom_range(65535));
        case ($urandom_range(3))
            1: it.fault_bits = 8'($urandom_range(255));
            2:
            begin
                case ($urandom_range(3))
                    0: it.fault_bits[FAULT_TH_BIT]   = 1'b1;
                    1: it.fault_bits[FAULT_RAIN_BIT] = 1'b1;
                    2: it.fault_bits[FAULT_CO2_BIT]  = 1'b1;
                    default: it.fault_bits[FAULT_CO_BIT] = 1'b1;
                endcase
            end
            default: it.fault_bits = '0;
        endcase
        return it;
    endfunction

    task automatic send_sample(input logic [7:0] t, input logic [7:0] h, input logic r,
                               input logic [15:0] c2, input logic [15:0] c1,
                               input logic [7:0] f);
        sensor_item_t it;
        it             = '0;
        it.command     = CMD_SAMPLE;
        it.temperature = t;
        it.humidity    = h;
        it.rain_raw    = r;
        it.co2_level   = c2;
        it.co_level    = c1;
        it.fault_bits  = f;
        send_item(it);
    endtask

    task automatic send_tick();
        send_item(random_item(100));
    endtask

    // drop tvalid, wait for all expected beats, then let the sequencer finish
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (sb.expected_means.size() != 0);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin tx_idle_pct = 61; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 61; end
            3:       begin tx_idle_pct = 32; rx_stall_pct = 32; end
            default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    initial
    begin : stimulus
        int          ph;
        int          k;
        int          n_items;
        int          tick_pct;
        logic [31:0] period;
        logic [3:0]  ratio;

        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SAMPLE;
        m_axis_tready = 1'b0;
        rx_hold       = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        sb = new;
        sb.clear_all();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes and each fault channel under reset defaults
        send_sample(8'hFF, 8'hFF, 1'b1, 16'hFFFF, 16'hFFFF, 8'h00);
        send_sample(8'h00, 8'h00, 1'b0, 16'h0000, 16'h0000, 8'h00);
        send_sample(8'd200, 8'd100, 1'b0, 16'd1234, 16'd4321, 8'hFF);
        send_sample(8'd17, 8'd90, 1'b0, 16'd500, 16'd600, 8'h01);
        send_sample(8'd30, 8'd40, 1'b0, 16'd700, 16'd800, 8'h02);
        send_sample(8'd25, 8'd60, 1'b0, 16'd900, 16'd1000, 8'h08);
        send_sample(8'd10, 8'd20, 1'b0, 16'd1100, 16'd1200, 8'h10);
        // close with ticks, then an empty period
        write_reg(REG_PERIOD, 32'd2);
        send_tick();
        send_tick();
        send_tick();
        send_tick();
        // period of zero: every sample closes, a lone tick closes empty
        write_reg(REG_PERIOD, 32'd0);
        send_sample(8'd55, 8'd66, 1'b0, 16'd77, 16'd88, 8'hE4);
        send_tick();
        // rain threshold corners
        write_reg(REG_RATIO, 32'd0);
        send_sample(8'd1, 8'd2, 1'b1, 16'd3, 16'd4, 8'h00);
        write_reg(REG_RATIO, 32'd15);
        send_sample(8'd5, 8'd6, 1'b0, 16'd7, 16'd8, 8'h00);
        write_reg(REG_RATIO, 32'd10);
        send_sample(8'd9, 8'd10, 1'b0, 16'd11, 16'd12, 8'h00);
        // largest period, then lower it so a sample closes the period
        write_reg(REG_PERIOD, 32'hFFFF_FFFF);
        send_sample(8'd100, 8'd50, 1'b0, 16'd400, 16'd20, 8'h00);
        send_tick();
        send_tick();
        send_tick();
        send_sample(8'd120, 8'd70, 1'b1, 16'd450, 16'd30, 8'h00);
        write_reg(REG_PERIOD, 32'd2);
        send_sample(8'd140, 8'd80, 1'b0, 16'd500, 16'd40, 8'h00);
        send_sample(8'hFF, 8'hFF, 1'b0, 16'hFFFF, 16'hFFFF, 8'h00);
        send_tick();
        send_tick();

        // random phases
        for (ph = 0; ph < 8; ph++)
        begin
            n_items = 150;
            case (ph)
                0: begin period = $urandom_range(4, 1);   ratio = 4'd3;  tick_pct = 30; end
                1: begin period = 32'd0;                  ratio = 4'($urandom_range(15));
                         tick_pct = 10; end
                2: begin period = $urandom_range(10, 2);  ratio = 4'd0;  tick_pct = 40; end
                3: begin period = 32'hFFFF_FFFF;          ratio = 4'd15; tick_pct = 25;
                         n_items = 60; end
                4: begin period = 32'd1;                  ratio = 4'd10; tick_pct = 50; end
                5: begin period = 32'd20;                 ratio = 4'($urandom_range(15));
                         tick_pct = 70; end
                6: begin period = 32'd2;                  ratio = 4'($urandom_range(15, 11));
                         tick_pct = 50; end
                default: begin period = $urandom_range(6); ratio = 4'($urandom_range(15));
                               tick_pct = 35; end
            endcase
            write_reg(REG_PERIOD, period);
            write_reg(REG_RATIO, {28'd0, ratio});
            set_idling(ph % 4);

            // long receiver hold-off while every sample closes a period
            if (ph == 1)
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge clk);
                        rx_hold <= 1'b0;
                    end
                join_none

            for (k = 0; k < n_items; k++)
                send_item(random_item(tick_pct));
        end

        wait_for_idle();
        if (sb.errors == 0 && sb.expected_means.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/psa_pkg.sv
rtl/core/psa_div.sv
rtl/core/psa_seq.sv
rtl/core/periodic_sensor_averager.sv
tb/testbench.sv
